// ----- rtl/qdc_pkg.sv -----
// shared constants for the dual quadrature counter odometer
`timescale 1ns / 1ps

package qdc_pkg;

    // default width of the position counters
    localparam int COUNT_BITS_DEFAULT = 32;

    // field widths of the result word
    localparam int OUT_COUNT_BITS = 32;
    localparam int DIST_BITS      = 56;
    localparam int DPP_BITS       = 24;

    // split point of the distance multiply
    localparam int MUL_SPLIT = 24;

    // stream word widths
    localparam int S_DATA_BITS = 8;
    localparam int M_DATA_BITS = 2 * OUT_COUNT_BITS + DIST_BITS;

    // configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // register indexes
    localparam logic REG_EDGE_MODE = 1'b0;
    localparam logic REG_DIST_PER_PULSE = 1'b1;

    // edge mode codes
    localparam logic [1:0] EDGE_RISING  = 2'd0;
    localparam logic [1:0] EDGE_FALLING = 2'd1;
    localparam logic [1:0] EDGE_BOTH    = 2'd2;

    // register reset values
    localparam logic [1:0]          EDGE_MODE_RESET = EDGE_RISING;
    localparam logic [DPP_BITS-1:0] DPP_RESET       = 24'd380097;

    // input command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_CLEAR_A = 1'b1;

endpackage

// ----- rtl/qdc_channel.sv -----
// next count of one quadrature encoder channel from previous and current levels
`timescale 1ns / 1ps

module qdc_channel #(
    parameter int COUNT_BITS = qdc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic [1:0]            edge_mode,
    input  logic [1:0]            prev_levels,  // bit 0 phase a, bit 1 phase b
    input  logic [1:0]            cur_levels,   // bit 0 phase a, bit 1 phase b
    input  logic [COUNT_BITS-1:0] count,
    output logic [COUNT_BITS-1:0] count_next
);
    import qdc_pkg::*;

    logic edge_a;
    logic edge_b;

    // edge detection per selected polarity, modes two and three count both
    always_comb
    begin
        case (edge_mode)
            EDGE_RISING:
            begin
                edge_a = !prev_levels[0] && cur_levels[0];
                edge_b = !prev_levels[1] && cur_levels[1];
            end
            EDGE_FALLING:
            begin
                edge_a = prev_levels[0] && !cur_levels[0];
                edge_b = prev_levels[1] && !cur_levels[1];
            end
            default:
            begin
                edge_a = prev_levels[0] ^ cur_levels[0];
                edge_b = prev_levels[1] ^ cur_levels[1];
            end
        endcase
    end

    // a edge wins over b edge; direction from the other phase level
    always_comb
    begin
        if (edge_a)
        begin
            count_next = cur_levels[1] ? count + COUNT_BITS'(1) : count - COUNT_BITS'(1);
        end
        else if (edge_b)
        begin
            count_next = cur_levels[0] ? count - COUNT_BITS'(1) : count + COUNT_BITS'(1);
        end
        else
        begin
            count_next = count;
        end
    end

endmodule

// ----- rtl/dual_quadrature_counter_odometer_core.sv -----
// top level of the dual quadrature counter odometer
`timescale 1ns / 1ps

// Dual quadrature encoder counter with a distance output for encoder one.
// Input stream: one word per pin sample. tuser carries the command (sample
// pins or clear encoder one's count); tdata carries the four phase levels.
// Output stream: one word per input word with both counts and encoder one's
// distance in centimeters (signed Q40.16), count times the per-pulse scale.
// Configuration: APB registers edge_mode at 0x0 and the per-pulse scale at 0x4;
// the user must write them only while the stream is idle, unchecked by the block.
// Pipeline: input register, count stage, partial product stage, result register.
// Throughput: one word per cycle while the receiver is ready; the counter
// update is a single increment or decrement and the 56-bit distance product
// is split into 24x24 and 32x24 partial products registered before the final add.
// Reset clears both counters, the previous levels, the pipeline valid flags
// and loads the register defaults. When the receiver stalls, each stage
// holds its word and input is still taken until all four stages are full.
module dual_quadrature_counter_odometer_core #(
    parameter int COUNT_BITS = qdc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: first_phase_a, first_phase_b, second_phase_a, second_phase_b, zero pad
    input  logic [qdc_pkg::S_DATA_BITS-1:0]    s_axis_tdata,
    // tuser: command
    input  logic                               s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: first_count [31:0], second_count [63:32], first_distance [119:64]
    output logic [qdc_pkg::M_DATA_BITS-1:0]    m_axis_tdata,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qdc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [qdc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [qdc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import qdc_pkg::*;

    localparam int HI_BITS = DIST_BITS - MUL_SPLIT;
    localparam int LO_BITS = 2 * MUL_SPLIT;

    // configuration registers
    logic [1:0]          edge_mode_reg;
    logic [DPP_BITS-1:0] dpp_reg;

    // stage one: input register
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [3:0] in_levels_reg;

    // counter state
    logic [3:0]            prev_levels_reg;
    logic [COUNT_BITS-1:0] first_counter_reg;
    logic [COUNT_BITS-1:0] second_counter_reg;
    logic [COUNT_BITS-1:0] first_step;
    logic [COUNT_BITS-1:0] second_step;
    logic [COUNT_BITS-1:0] first_counter_next;
    logic [COUNT_BITS-1:0] second_counter_next;
    logic [3:0]            prev_levels_next;
    logic [DIST_BITS-1:0]  first_ext;
    logic [DIST_BITS-1:0]  second_ext;

    // stage two: counts
    logic                      cnt_valid_reg;
    logic [OUT_COUNT_BITS-1:0] cnt_first_reg;
    logic [OUT_COUNT_BITS-1:0] cnt_second_reg;
    logic [DIST_BITS-1:0]      cnt_ext_reg;

    // stage three: partial products
    logic                         pp_valid_reg;
    logic [OUT_COUNT_BITS-1:0]    pp_first_reg;
    logic [OUT_COUNT_BITS-1:0]    pp_second_reg;
    logic [LO_BITS-1:0]           pp_lo_reg;
    logic [HI_BITS-1:0]           pp_hi_reg;
    logic [LO_BITS-1:0]           pp_lo_next;
    logic [HI_BITS-1:0]           pp_hi_next;

    // stage four: result register
    logic                      out_valid_reg;
    logic [OUT_COUNT_BITS-1:0] out_first_reg;
    logic [OUT_COUNT_BITS-1:0] out_second_reg;
    logic [DIST_BITS-1:0]      out_dist_reg;
    logic [DIST_BITS-1:0]      dist_next;

    // stage load enables
    logic in_load;
    logic cnt_load;
    logic pp_load;
    logic out_load;

    assign out_load      = pp_valid_reg && (!out_valid_reg || m_axis_tready);
    assign pp_load       = cnt_valid_reg && (!pp_valid_reg || out_load);
    assign cnt_load      = in_valid_reg && (!cnt_valid_reg || pp_load);
    assign s_axis_tready = !in_valid_reg || cnt_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // configuration write and read
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_mode_reg <= EDGE_MODE_RESET;
            dpp_reg       <= DPP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_EDGE_MODE:      edge_mode_reg <= pwdata[1:0];
                REG_DIST_PER_PULSE: dpp_reg       <= pwdata[DPP_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_EDGE_MODE:      prdata = {{(APB_DATA_BITS-2){1'b0}}, edge_mode_reg};
            REG_DIST_PER_PULSE: prdata = {{(APB_DATA_BITS-DPP_BITS){1'b0}}, dpp_reg};
            default:            prdata = '0;
        endcase
    end

    // per-channel step logic
    qdc_channel #(
        .COUNT_BITS (COUNT_BITS)
    ) u_first (
        .edge_mode   (edge_mode_reg),
        .prev_levels (prev_levels_reg[1:0]),
        .cur_levels  (in_levels_reg[1:0]),
        .count       (first_counter_reg),
        .count_next  (first_step)
    );

    qdc_channel #(
        .COUNT_BITS (COUNT_BITS)
    ) u_second (
        .edge_mode   (edge_mode_reg),
        .prev_levels (prev_levels_reg[3:2]),
        .cur_levels  (in_levels_reg[3:2]),
        .count       (second_counter_reg),
        .count_next  (second_step)
    );

    // clear zeroes encoder one only and takes no sample
    always_comb
    begin
        case (in_cmd_reg)
            CMD_CLEAR_A:
            begin
                first_counter_next  = '0;
                second_counter_next = second_counter_reg;
                prev_levels_next    = prev_levels_reg;
            end
            default:
            begin
                first_counter_next  = first_step;
                second_counter_next = second_step;
                prev_levels_next    = in_levels_reg;
            end
        endcase
    end

    // sign extension of the new counts
    assign first_ext  = {{(DIST_BITS-COUNT_BITS){first_counter_next[COUNT_BITS-1]}},
                         first_counter_next};
    assign second_ext = {{(DIST_BITS-COUNT_BITS){second_counter_next[COUNT_BITS-1]}},
                         second_counter_next};

    // partial products of the distance, modulo 2^56
    assign pp_lo_next = LO_BITS'(cnt_ext_reg[MUL_SPLIT-1:0]) * LO_BITS'(dpp_reg);
    assign pp_hi_next = cnt_ext_reg[DIST_BITS-1:MUL_SPLIT] * HI_BITS'(dpp_reg);
    assign dist_next  = {pp_hi_reg, {MUL_SPLIT{1'b0}}}
                      + {{(DIST_BITS-LO_BITS){1'b0}}, pp_lo_reg};

    // valid flags and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            cnt_valid_reg      <= 1'b0;
            pp_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            prev_levels_reg    <= '0;
            first_counter_reg  <= '0;
            second_counter_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (!cnt_valid_reg || pp_load)
            begin
                cnt_valid_reg <= cnt_load;
            end
            if (!pp_valid_reg || out_load)
            begin
                pp_valid_reg <= pp_load;
            end
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg <= out_load;
            end
            if (cnt_load)
            begin
                prev_levels_reg    <= prev_levels_next;
                first_counter_reg  <= first_counter_next;
                second_counter_reg <= second_counter_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_cmd_reg    <= s_axis_tuser;
            in_levels_reg <= s_axis_tdata[3:0];
        end
        if (cnt_load)
        begin
            cnt_first_reg  <= first_ext[OUT_COUNT_BITS-1:0];
            cnt_second_reg <= second_ext[OUT_COUNT_BITS-1:0];
            cnt_ext_reg    <= first_ext;
        end
        if (pp_load)
        begin
            pp_first_reg  <= cnt_first_reg;
            pp_second_reg <= cnt_second_reg;
            pp_lo_reg     <= pp_lo_next;
            pp_hi_reg     <= pp_hi_next;
        end
        if (out_load)
        begin
            out_first_reg  <= pp_first_reg;
            out_second_reg <= pp_second_reg;
            out_dist_reg   <= dist_next;
        end
    end

    // result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_dist_reg, out_second_reg, out_first_reg};

endmodule
